// ----- hdl/slcc_pkg.sv -----
// Shared types and constants for the sensor line crosstalk calibration unit.
package slcc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int REF_W      = 13;
  localparam int SUM_W      = 13;
  localparam int CAL_W      = 8;
  localparam int CELL_IDX_W = 6;
  localparam int REM_W      = 14;
  localparam int DIFF_W     = 15;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF    = 1'd1;

  localparam logic [SAMPLE_W-1:0] SUM_MIN_SAMPLE = 12'd10;
  localparam logic [SAMPLE_W-1:0] DARK_LIMIT     = 12'd3;
  localparam logic [SUM_W-1:0]    SUM_CEIL       = 13'd4096;
  localparam logic [REF_W-1:0]    REF_RESET      = 13'd4030;
  localparam logic [CAL_W-1:0]    CAL_MAX        = 8'd255;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = 8;
  localparam int STEP_W    = 3;

  typedef struct packed {
    logic load;
    logic rd;
    logic calc;
    logic div_step;
    logic next_cell;
    logic clear;
  } slcc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic last_cell;
  } slcc_sts_t;

endpackage

// ----- hdl/sensor_line_crosstalk_calibration_unit.sv -----
// Top level of the sensor line crosstalk calibration unit.
// Collects the 12-bit samples of one sensor line into a LINE_CELLS-deep buffer
// while keeping a running line sum (samples under 10 skipped, sum saturating
// at 4096). A sample marked end_of_line closes the line; the unit then emits
// one calibrated byte per buffered cell, in arrival order, with its cell index
// and a last-of-line flag, and clears the sum and fill count. A sample that
// arrives with the buffer already full is dropped, but its end-of-line mark
// still closes the line. Samples are taken only while the unit is idle. At
// end of line every cell costs a buffer read, an evaluate step and an output
// step, plus the one-bit-per-cycle shift-subtract divider when crosstalk
// division is needed; the output step waits while out_stall is high. No input
// is taken during emission. Register writes (calibrate_enable at index 0,
// reference_level at index 1) take effect at the next edge and are sampled
// during emission. The buffer needs no clearing pass after reset.
module sensor_line_crosstalk_calibration_unit import slcc_pkg::*; #(
  parameter int LINE_CELLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_raw_sample,
  input  logic                  in_end_of_line,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CAL_W-1:0]      out_cal_value,
  output logic [CELL_IDX_W-1:0] out_cell_index,
  output logic                  out_last_of_line
);

  logic             cal_en_r;
  logic [REF_W-1:0] ref_r;
  slcc_cmd_t        cmd;
  slcc_sts_t        sts;

  // Configuration registers; no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_en_r <= 1'b1;
      ref_r    <= REF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_EN: cal_en_r <= cfg_data[0];
        CFG_REF:    ref_r    <= cfg_data[REF_W-1:0];
        default:    ;
      endcase
    end
  end

  slcc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_line (in_end_of_line),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  slcc_dpath #(
    .LINE_CELLS (LINE_CELLS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cal_en         (cal_en_r),
    .ref_level      (ref_r),
    .in_raw_sample  (in_raw_sample),
    .sts            (sts),
    .out_cal_value  (out_cal_value),
    .out_cell_index (out_cell_index)
  );

  assign out_last_of_line = sts.last_cell;

  // No item is taken while a result is on offer.
  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during emission");

  // A line end starts emission on the next cycle.
  a_eol_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_line) |=> in_stall)
    else $error("line end did not start emission");

  // After a non-final result the next cell needs a buffer read first.
  a_gap_between_cells: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_line) |=> (!out_valid && in_stall))
    else $error("missing read cycle between cells");

  // The final result of a line returns the unit to loading.
  a_line_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_line) |=> (!in_stall && !out_valid))
    else $error("unit not idle after line end");

endmodule

// ----- hdl/slcc_dpath.sv -----
// Datapath: line buffer, running sum, cell counter and the shift-subtract divider.
module slcc_dpath import slcc_pkg::*; #(
  parameter int LINE_CELLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slcc_cmd_t             cmd,
  input  logic                  cal_en,
  input  logic [REF_W-1:0]      ref_level,
  input  logic [SAMPLE_W-1:0]   in_raw_sample,
  output slcc_sts_t             sts,
  output logic [CAL_W-1:0]      out_cal_value,
  output logic [CELL_IDX_W-1:0] out_cell_index
);

  localparam int IDX_W = (LINE_CELLS > 1) ? $clog2(LINE_CELLS) : 1;
  localparam int CNT_W = $clog2(LINE_CELLS + 1);

  logic [SAMPLE_W-1:0] buf_mem [LINE_CELLS];

  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SUM_W:0]      sum_add;
  logic                full;

  logic [SAMPLE_W-1:0] s_r;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [REM_W-1:0]    div_r;
  logic [CAL_W-1:0]    res_r;
  logic [CAL_W-1:0]    calc_res;
  logic signed [DIFF_W-1:0] diff;
  logic [REM_W:0]      trial;
  logic                q_bit;
  logic                need_div;
  logic                last_cell;
  logic [CNT_W+CELL_IDX_W-1:0] k_ext;

  assign full    = (fill_r >= CNT_W'(LINE_CELLS));
  assign sum_add = {1'b0, sum_r} + {2'b00, in_raw_sample};

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    k_nxt    = k_r;
    if (cmd.load && !full) begin
      fill_nxt = fill_r + CNT_W'(1);
      if (in_raw_sample >= SUM_MIN_SAMPLE) begin
        sum_nxt = (sum_add > {1'b0, SUM_CEIL}) ? SUM_CEIL : sum_add[SUM_W-1:0];
      end
    end
    if (cmd.next_cell) begin
      k_nxt = k_r + CNT_W'(1);
    end
    if (cmd.clear) begin
      fill_nxt = '0;
      sum_nxt  = '0;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
      k_r    <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      k_r    <= k_nxt;
    end
  end

  // Buffer write on load, registered read of the current cell.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      buf_mem[fill_r[IDX_W-1:0]] <= in_raw_sample;
    end
    if (cmd.rd) begin
      s_r <= buf_mem[k_r[IDX_W-1:0]];
    end
  end

  // Signed distance of the reference from the crosstalk of the other cells.
  assign diff = $signed({2'b00, ref_level}) + $signed({3'b000, s_r})
              - $signed({2'b00, sum_r});

  always_comb begin
    need_div = 1'b0;
    if (s_r < DARK_LIMIT) begin
      calc_res = '0;
    end else if (!cal_en) begin
      calc_res = s_r[SAMPLE_W-1:4];
    end else if (diff < 0) begin
      calc_res = '0;
    end else if (diff == 0) begin
      calc_res = CAL_MAX;
    end else begin
      // Quotient of 512*s/d reaches 256 exactly when 2*s >= d.
      calc_res = CAL_MAX;
      need_div = ({1'b0, s_r, 1'b0} < diff[REM_W-1:0]);
    end
  end

  assign trial   = {rem_r, 1'b0};
  assign q_bit   = (trial >= {1'b0, div_r});
  assign rem_nxt = q_bit ? REM_W'(trial - {1'b0, div_r}) : trial[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res_r <= calc_res;
      rem_r <= {1'b0, s_r, 1'b0};
      div_r <= diff[REM_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      res_r <= {res_r[CAL_W-2:0], q_bit};
    end
  end

  assign last_cell      = ((k_r + CNT_W'(1)) == fill_r);
  assign sts            = '{need_div: need_div, last_cell: last_cell};
  assign k_ext          = {{CELL_IDX_W{1'b0}}, k_r};
  assign out_cell_index = k_ext[CELL_IDX_W-1:0];
  assign out_cal_value  = res_r;

endmodule

// ----- hdl/slcc_ctrl.sv -----
// Controller: sequences loading, per-cell evaluation, division and result handoff.
module slcc_ctrl import slcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_end_of_line,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  slcc_sts_t sts,
  output slcc_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_end_of_line) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.need_div ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (sts.last_cell) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_cell = 1'b1;
            state_nxt     = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule
